// ----- rtl/stlm_pkg.sv -----
// Shared types, widths and register codes of the segment-to-line metrics core.
package stlm_pkg;

  // Field and intermediate widths (derived from the 32-bit coordinate format where not set directly)
  localparam int COORD_W         = 32;
  localparam int DIFF_W          = COORD_W + 1;       // coordinate difference
  localparam int PROD_W          = 2 * DIFF_W;        // product of two differences
  localparam int CROSS_W         = PROD_W + 1;        // cross product component
  localparam int CS_W            = CROSS_W + 1;       // sum of two cross components
  localparam int DOT_W           = PROD_W + 2;        // dot product, signed
  localparam int LEN_W           = PROD_W;            // squared line length
  localparam int HALF_W          = DIFF_W;            // half of a magnitude
  localparam int MAG_W           = 2 * HALF_W;        // magnitude of a cross sum
  localparam int PP_W            = 2 * HALF_W;        // partial product
  localparam int SQ_W            = 2 * MAG_W;         // square of a magnitude
  localparam int VS_W            = SQ_W + 2;          // sum of three squares
  localparam int T_W             = VS_W + 2;          // total of nine squares
  localparam int DEN6_W          = LEN_W + 3;         // six times squared length
  localparam int GAP_NUM_W       = DOT_W - 1;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int LAT_Q_W         = 48;
  localparam int GAP_Q_W         = 31;
  localparam int OVL_Q_W         = 17;
  localparam int DIV_LAT         = LAT_Q_W + 1;
  localparam int GEOM_LAT        = 3;
  localparam int ENERGY_LAT      = 6;
  localparam int COORD_FRAC_DEF  = 16;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LINE_END_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_END_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LINE_END_Z   = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [CS_W-1:0]    cs_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  // Three coordinates, x in the lowest bits
  typedef coord_t [2:0] vec_t;

  // Pair of end points, first point in the lowest bits
  typedef struct packed {
    vec_t p1;
    vec_t p0;
  } seg_t;

  // Geometry of one item after the cross and dot products
  typedef struct {
    cross_t           ca [3];
    cross_t           cb [3];
    logic [LEN_W-1:0] len2;
    dot_t             n0;
    dot_t             n1;
  } geom_t;

  // Numerators and divisors for the ratio dividers
  typedef struct packed {
    logic [GAP_NUM_W-1:0] gap_num;
    logic [LEN_W-1:0]     ovl_num;
    logic [LEN_W-1:0]     len2;
    logic [DEN6_W-1:0]    den6;
    logic                 degen;
  } num_t;

endpackage

// ----- rtl/stlm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating.
module stlm_div #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 66,
  parameter int Q_W   = 17,
  parameter int LAT   = Q_W + 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]  rem_q [LAT];
  logic [CW-1:0]  den_q [LAT];
  logic [Q_W-1:0] quo_q [LAT];
  logic           sat_q [LAT];

  // First stage: overflow check against the full quotient range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(num_i);
      den_q[0] <= CW'(den_i);
      sat_q[0] <= CW'(num_i) >= (CW'(den_i) << Q_W);
      quo_q[0] <= '0;
    end
  end

  // One quotient bit per stage, then plain delay up to the set latency
  for (genvar s = 1; s < LAT; s++) begin : g_stage
    if (s <= Q_W) begin : g_bit
      logic [CW-1:0] shf;
      logic          ge;
      assign shf = den_q[s-1] << (Q_W - s);
      assign ge  = rem_q[s-1] >= shf;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? rem_q[s-1] - shf : rem_q[s-1];
          den_q[s] <= den_q[s-1];
          quo_q[s] <= quo_q[s-1] | (Q_W'(ge) << (Q_W - s));
          sat_q[s] <= sat_q[s-1];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_q[s-1];
          den_q[s] <= den_q[s-1];
          quo_q[s] <= quo_q[s-1];
          sat_q[s] <= sat_q[s-1];
        end
      end
    end
  end

  assign quo_o = sat_q[LAT-1] ? '1 : quo_q[LAT-1];

endmodule

// ----- rtl/stlm_geom.sv -----
// Differences, cross and dot products of one segment against the line.
module stlm_geom (
  input  logic           clk_i,
  input  logic           en_i,
  input  stlm_pkg::seg_t line_i,
  input  stlm_pkg::seg_t seg_i,
  output stlm_pkg::geom_t geom_o
);
  import stlm_pkg::*;

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  diff_t  d_q [3];
  diff_t  a_q [3];
  diff_t  b_q [3];
  prod_t  pap_q [3];
  prod_t  pam_q [3];
  prod_t  pbp_q [3];
  prod_t  pbm_q [3];
  prod_t  ad_q [3];
  prod_t  bd_q [3];
  prod_t  dd_q [3];
  cross_t ca_q [3];
  cross_t cb_q [3];
  logic [LEN_W-1:0] len2_q;
  dot_t   n0_q;
  dot_t   n1_q;
  dot_t   len2_sum;

  // Stage 1: offsets from the line start
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= diff_t'($signed(line_i.p1[i])) - diff_t'($signed(line_i.p0[i]));
        a_q[i] <= diff_t'($signed(seg_i.p0[i])) - diff_t'($signed(line_i.p0[i]));
        b_q[i] <= diff_t'($signed(seg_i.p1[i])) - diff_t'($signed(line_i.p0[i]));
      end
    end
  end

  // Stage 2: all products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pap_q[i] <= prod_t'(a_q[NXT[i]]) * prod_t'(d_q[PRV[i]]);
        pam_q[i] <= prod_t'(a_q[PRV[i]]) * prod_t'(d_q[NXT[i]]);
        pbp_q[i] <= prod_t'(b_q[NXT[i]]) * prod_t'(d_q[PRV[i]]);
        pbm_q[i] <= prod_t'(b_q[PRV[i]]) * prod_t'(d_q[NXT[i]]);
        ad_q[i]  <= prod_t'(a_q[i]) * prod_t'(d_q[i]);
        bd_q[i]  <= prod_t'(b_q[i]) * prod_t'(d_q[i]);
        dd_q[i]  <= prod_t'(d_q[i]) * prod_t'(d_q[i]);
      end
    end
  end

  assign len2_sum = dot_t'(dd_q[0]) + dot_t'(dd_q[1]) + dot_t'(dd_q[2]);

  // Stage 3: cross components and dot sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ca_q[i] <= cross_t'(pap_q[i]) - cross_t'(pam_q[i]);
        cb_q[i] <= cross_t'(pbp_q[i]) - cross_t'(pbm_q[i]);
      end
      len2_q <= len2_sum[LEN_W-1:0];
      n0_q   <= dot_t'(ad_q[0]) + dot_t'(ad_q[1]) + dot_t'(ad_q[2]);
      n1_q   <= dot_t'(bd_q[0]) + dot_t'(bd_q[1]) + dot_t'(bd_q[2]);
    end
  end

  always_comb begin
    geom_o.ca   = ca_q;
    geom_o.cb   = cb_q;
    geom_o.len2 = len2_q;
    geom_o.n0   = n0_q;
    geom_o.n1   = n1_q;
  end

endmodule

// ----- rtl/stlm_energy.sv -----
// Sum of squared cross terms, plus gap and overlap numerator selection.
module stlm_energy (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  stlm_pkg::geom_t            geom_i,
  output logic [stlm_pkg::T_W-1:0]   t_o,
  output stlm_pkg::num_t             num_o
);
  import stlm_pkg::*;

  // E1 registers
  cs_t  ca1_q [3];
  cs_t  cb1_q [3];
  cs_t  cs1_q [3];
  dot_t lo1_q, hi1_q, n0_1_q, n1_1_q;
  logic [LEN_W-1:0]  len2_1_q;
  logic [DEN6_W-1:0] den6_1_q;
  logic              degen_1_q;
  // E2 registers
  logic [MAG_W-1:0]  mag_q [9];
  logic              n1neg_q, n0gt_q, disj_q, cover_q, loneg_q, higt_q;
  logic [GAP_NUM_W-1:0] negn1_q, n0ml_q;
  logic [LEN_W-1:0]  l2mlo_q, himlo_q, hi2_q, len2_2_q;
  logic [DEN6_W-1:0] den6_2_q;
  logic              degen_2_q;
  // E3..E6 registers
  logic [PP_W-1:0]   hh_q [9];
  logic [PP_W-1:0]   hl_q [9];
  logic [PP_W-1:0]   ll_q [9];
  logic [SQ_W-1:0]   sq_q [9];
  logic [VS_W-1:0]   vs_q [3];
  logic [T_W-1:0]    t_q;
  num_t              nq_q [4];

  cs_t   vals [9];
  cs_t   negv [9];
  dot_t  len2s;
  num_t  num_d;

  // E1: cross sum, end ordering, divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ca1_q[i] <= cs_t'(geom_i.ca[i]);
        cb1_q[i] <= cs_t'(geom_i.cb[i]);
        cs1_q[i] <= cs_t'(geom_i.ca[i]) + cs_t'(geom_i.cb[i]);
      end
      if (geom_i.n1 < geom_i.n0) begin
        lo1_q <= geom_i.n1;
        hi1_q <= geom_i.n0;
      end else begin
        lo1_q <= geom_i.n0;
        hi1_q <= geom_i.n1;
      end
      n0_1_q    <= geom_i.n0;
      n1_1_q    <= geom_i.n1;
      len2_1_q  <= geom_i.len2;
      den6_1_q  <= (DEN6_W'(geom_i.len2) << 2) + (DEN6_W'(geom_i.len2) << 1);
      degen_1_q <= (geom_i.len2 == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vals[i]     = ca1_q[i];
      vals[3 + i] = cb1_q[i];
      vals[6 + i] = cs1_q[i];
    end
    for (int i = 0; i < 9; i++) begin
      negv[i] = -vals[i];
    end
  end

  assign len2s = dot_t'(len2_1_q);

  // E2: magnitudes, compare flags and candidate numerators
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        mag_q[i] <= (vals[i] < 0) ? negv[i][MAG_W-1:0] : vals[i][MAG_W-1:0];
      end
      n1neg_q   <= n1_1_q < 0;
      n0gt_q    <= n0_1_q > len2s;
      negn1_q   <= GAP_NUM_W'(-n1_1_q);
      n0ml_q    <= GAP_NUM_W'(n0_1_q - len2s);
      disj_q    <= (hi1_q < 0) || (lo1_q > len2s);
      cover_q   <= (lo1_q < 0) && (hi1_q > len2s);
      loneg_q   <= lo1_q < 0;
      higt_q    <= hi1_q > len2s;
      l2mlo_q   <= LEN_W'(len2s - lo1_q);
      himlo_q   <= LEN_W'(hi1_q - lo1_q);
      hi2_q     <= LEN_W'(hi1_q);
      len2_2_q  <= len2_1_q;
      den6_2_q  <= den6_1_q;
      degen_2_q <= degen_1_q;
    end
  end

  // Numerator choice: gap by end, overlap by case
  always_comb begin
    num_d.len2  = len2_2_q;
    num_d.den6  = den6_2_q;
    num_d.degen = degen_2_q;
    if (n1neg_q) begin
      num_d.gap_num = negn1_q;
    end else if (n0gt_q) begin
      num_d.gap_num = n0ml_q;
    end else begin
      num_d.gap_num = '0;
    end
    priority if (disj_q) begin
      num_d.ovl_num = '0;
    end else if (cover_q) begin
      num_d.ovl_num = len2_2_q;
    end else if (loneg_q) begin
      num_d.ovl_num = hi2_q;
    end else if (higt_q) begin
      num_d.ovl_num = l2mlo_q;
    end else begin
      num_d.ovl_num = himlo_q;
    end
  end

  // E3: split squares into half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        hh_q[i] <= PP_W'(mag_q[i][MAG_W-1:HALF_W]) * PP_W'(mag_q[i][MAG_W-1:HALF_W]);
        hl_q[i] <= PP_W'(mag_q[i][MAG_W-1:HALF_W]) * PP_W'(mag_q[i][HALF_W-1:0]);
        ll_q[i] <= PP_W'(mag_q[i][HALF_W-1:0]) * PP_W'(mag_q[i][HALF_W-1:0]);
      end
      nq_q[0] <= num_d;
    end
  end

  // E4: recombine each square
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        sq_q[i] <= (SQ_W'(hh_q[i]) << (2 * HALF_W)) + (SQ_W'(hl_q[i]) << (HALF_W + 1))
                 + SQ_W'(ll_q[i]);
      end
      nq_q[1] <= nq_q[0];
    end
  end

  // E5: per-vector sums; E6: total
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int v = 0; v < 3; v++) begin
        vs_q[v] <= VS_W'(sq_q[3 * v]) + VS_W'(sq_q[3 * v + 1]) + VS_W'(sq_q[3 * v + 2]);
      end
      nq_q[2] <= nq_q[1];
      t_q     <= T_W'(vs_q[0]) + T_W'(vs_q[1]) + T_W'(vs_q[2]);
      nq_q[3] <= nq_q[2];
    end
  end

  assign t_o   = t_q;
  assign num_o = nq_q[3];

endmodule

// ----- rtl/segment_to_line_metrics_core.sv -----
// Pipeline from input item to result item: 3 product stages, 6 squaring stages, 49 divider
// stages, 1 output register; throughput one item per cycle while the output does not stall.
// The rate is held by the bit-per-stage dividers, one quotient bit per register stage.
// The whole pipeline stalls together only while a finished result waits at the output.
// Reset (async, active low) clears the valid bits and sets all six line registers to 0.
module segment_to_line_metrics_core #(
  parameter int COORD_FRAC_BITS = stlm_pkg::COORD_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [stlm_pkg::REG_IDX_W-1:0]  cfg_addr_i,
  input  logic [stlm_pkg::COORD_W-1:0]    cfg_wdata_i,
  // segment items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z
  input  logic [6*stlm_pkg::COORD_W-1:0]  s_axis_tdata,
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // lateral_dist_sq, gap_fraction, overlap_fraction
  output logic [95:0]                     m_axis_tdata,
  // degenerate_line
  output logic [0:0]                      m_axis_tuser
);
  import stlm_pkg::*;

  localparam int LAT_NUM_W = T_W - COORD_FRAC_BITS;
  localparam int PIPE_LAT  = GEOM_LAT + ENERGY_LAT + DIV_LAT;

  seg_t  line_q;
  seg_t  seg_in;
  geom_t geom;
  logic [T_W-1:0] t_sum;
  num_t  num;
  logic  en;
  logic [PIPE_LAT-1:0] vld_q;
  logic [DIV_LAT-1:0]  dg_q;
  logic [LAT_Q_W-1:0]  lat_quo;
  logic [GAP_Q_W-1:0]  gap_quo;
  logic [OVL_Q_W-1:0]  ovl_quo;
  logic                out_valid_q;
  logic [LAT_Q_W-1:0]  lat_q;
  logic [GAP_Q_W-1:0]  gap_q;
  logic [OVL_Q_W-1:0]  ovl_q;
  logic                degen_q;

  // Line end point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LINE_START_X: line_q.p0[0] <= cfg_wdata_i;
        REG_LINE_START_Y: line_q.p0[1] <= cfg_wdata_i;
        REG_LINE_START_Z: line_q.p0[2] <= cfg_wdata_i;
        REG_LINE_END_X:   line_q.p1[0] <= cfg_wdata_i;
        REG_LINE_END_Y:   line_q.p1[1] <= cfg_wdata_i;
        REG_LINE_END_Z:   line_q.p1[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result is held at the output
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign seg_in        = seg_t'(s_axis_tdata);

  stlm_geom u_geom (
    .clk_i  (clk_i),
    .en_i   (en),
    .line_i (line_q),
    .seg_i  (seg_in),
    .geom_o (geom)
  );

  stlm_energy u_energy (
    .clk_i  (clk_i),
    .en_i   (en),
    .geom_i (geom),
    .t_o    (t_sum),
    .num_o  (num)
  );

  stlm_div #(
    .NUM_W (LAT_NUM_W),
    .DEN_W (DEN6_W),
    .Q_W   (LAT_Q_W),
    .LAT   (DIV_LAT)
  ) u_div_lat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (t_sum[T_W-1:COORD_FRAC_BITS]),
    .den_i (num.den6),
    .quo_o (lat_quo)
  );

  stlm_div #(
    .NUM_W (GAP_NUM_W + RATIO_FRAC_BITS),
    .DEN_W (LEN_W),
    .Q_W   (GAP_Q_W),
    .LAT   (DIV_LAT)
  ) u_div_gap (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({num.gap_num, {RATIO_FRAC_BITS{1'b0}}}),
    .den_i (num.len2),
    .quo_o (gap_quo)
  );

  stlm_div #(
    .NUM_W (LEN_W + RATIO_FRAC_BITS),
    .DEN_W (LEN_W),
    .Q_W   (OVL_Q_W),
    .LAT   (DIV_LAT)
  ) u_div_ovl (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({num.ovl_num, {RATIO_FRAC_BITS{1'b0}}}),
    .den_i (num.len2),
    .quo_o (ovl_quo)
  );

  // Valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  // Degenerate flag kept in step with the dividers; output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q    <= {dg_q[DIV_LAT-2:0], num.degen};
      degen_q <= dg_q[DIV_LAT-1];
      lat_q   <= dg_q[DIV_LAT-1] ? '0 : lat_quo;
      gap_q   <= dg_q[DIV_LAT-1] ? '0 : gap_quo;
      ovl_q   <= dg_q[DIV_LAT-1] ? '0 : ovl_quo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ovl_q, gap_q, lat_q};
  assign m_axis_tuser  = degen_q;

endmodule

// ----- verif/segment_to_line_metrics_checker.sv -----
// Checker for the segment-to-line metrics core: watches the channels, predicts and compares.
module segment_to_line_metrics_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [stlm_pkg::REG_IDX_W-1:0]     cfg_addr_i,
  input  logic [stlm_pkg::COORD_W-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [6*stlm_pkg::COORD_W-1:0]     s_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [95:0]                        m_axis_tdata,
  input  logic [0:0]                         m_axis_tuser,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 degen_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stlm_pkg::*;

  typedef logic signed [199:0] big_t;

  typedef struct {
    logic [LAT_Q_W-1:0] lat;
    logic [GAP_Q_W-1:0] gap;
    logic [OVL_Q_W-1:0] ovl;
    logic               degen;
  } metrics_t;

  localparam big_t LAT_SAT = (big_t'(1) <<< LAT_Q_W) - 1;
  localparam big_t GAP_SAT = (big_t'(1) <<< GAP_Q_W) - 1;
  localparam big_t OVL_ONE = big_t'(1) <<< RATIO_FRAC_BITS;

  coord_t   line_q [6];
  metrics_t metrics_q [$];

  // floor(num * 2^16 / len2), saturated
  function automatic big_t frac_of_len(big_t num, big_t len2, big_t lim);
    big_t q;
    q = (num <<< RATIO_FRAC_BITS) / len2;
    return (q > lim) ? lim : q;
  endfunction

  function automatic metrics_t line_metrics(logic [6*COORD_W-1:0] seg);
    big_t     d [3], a [3], b [3], ca [3], cb [3], cs [3];
    big_t     len2, n0, n1, t, den, q, lo, hi;
    metrics_t m;
    for (int i = 0; i < 3; i++) begin
      d[i] = big_t'(line_q[i+3]) - big_t'(line_q[i]);
      a[i] = big_t'(coord_t'(seg[i*COORD_W +: COORD_W])) - big_t'(line_q[i]);
      b[i] = big_t'(coord_t'(seg[(i+3)*COORD_W +: COORD_W])) - big_t'(line_q[i]);
    end
    m = '{lat: '0, gap: '0, ovl: '0, degen: 1'b0};
    len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    if (len2 == 0) begin
      m.degen = 1'b1;
      return m;
    end
    ca[0] = a[1]*d[2] - a[2]*d[1];
    ca[1] = a[2]*d[0] - a[0]*d[2];
    ca[2] = a[0]*d[1] - a[1]*d[0];
    cb[0] = b[1]*d[2] - b[2]*d[1];
    cb[1] = b[2]*d[0] - b[0]*d[2];
    cb[2] = b[0]*d[1] - b[1]*d[0];
    t = 0;
    for (int i = 0; i < 3; i++) begin
      cs[i] = ca[i] + cb[i];
      t += ca[i]*ca[i] + cb[i]*cb[i] + cs[i]*cs[i];
    end
    den = (len2 * 6) <<< COORD_FRAC_DEF;
    q = t / den;
    m.lat = (q > LAT_SAT) ? LAT_SAT[LAT_Q_W-1:0] : q[LAT_Q_W-1:0];
    n0 = a[0]*d[0] + a[1]*d[1] + a[2]*d[2];
    n1 = b[0]*d[0] + b[1]*d[1] + b[2]*d[2];
    // gap: segment end before the line start first, then segment start past the line end
    if (n1 < 0) m.gap = GAP_Q_W'(frac_of_len(-n1, len2, GAP_SAT));
    else if (n0 > len2) m.gap = GAP_Q_W'(frac_of_len(n0 - len2, len2, GAP_SAT));
    lo = (n1 < n0) ? n1 : n0;
    hi = (n1 < n0) ? n0 : n1;
    if (hi < 0 || lo > len2) m.ovl = '0;
    else if (lo < 0 && hi > len2) m.ovl = OVL_Q_W'(OVL_ONE);
    else if (lo < 0) m.ovl = OVL_Q_W'(frac_of_len(hi, len2, OVL_ONE));
    else if (hi > len2) m.ovl = OVL_Q_W'(frac_of_len(len2 - lo, len2, OVL_ONE));
    else m.ovl = OVL_Q_W'(frac_of_len(hi - lo, len2, OVL_ONE));
    return m;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  assign pending_o = metrics_q.size();

  // Monitor: register writes, accepted segments, accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    metrics_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) line_q[i] = '0;
      metrics_q.delete();
      errors_o     = 0;
      checked_o    = 0;
      degen_seen_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (metrics_q.size() == 0) begin
          $display("[%0t] result item with nothing expected", $realtime);
          errors_o++;
        end else begin
          want = metrics_q.pop_front();
          checked_o++;
          if (want.degen) degen_seen_o++;
          if (m_axis_tdata[47:0] !== want.lat)
            report_mismatch("lateral_dist_sq", m_axis_tdata[47:0], want.lat);
          if (m_axis_tdata[78:48] !== want.gap)
            report_mismatch("gap_fraction", m_axis_tdata[78:48], want.gap);
          if (m_axis_tdata[95:79] !== want.ovl)
            report_mismatch("overlap_fraction", m_axis_tdata[95:79], want.ovl);
          if (m_axis_tuser[0] !== want.degen)
            report_mismatch("degenerate_line", m_axis_tuser[0], want.degen);
        end
      end
      if (s_axis_tvalid && s_axis_tready) metrics_q = {metrics_q, line_metrics(s_axis_tdata)};
      if (cfg_we_i && cfg_addr_i <= REG_LINE_END_Z) line_q[cfg_addr_i] = coord_t'(cfg_wdata_i);
    end
  end

endmodule

// ----- verif/segment_to_line_metrics_core_tb.sv -----
// Testbench top for the segment-to-line metrics core: stimulus, line settings and verdict.
module segment_to_line_metrics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stlm_pkg::*;

  localparam int ITEMS_PER_LINE = 255;
  localparam int CYCLE_LIMIT    = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [COORD_W-1:0]    cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [6*COORD_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [95:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  int  errors, pending, checked, degen_seen;
  int  sent = 0;
  int  settings = 1;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  coord_t line_cur [6];

  segment_to_line_metrics_core i_dut (.*);

  segment_to_line_metrics_checker i_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending), .checked_o(checked),
    .degen_seen_o(degen_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    static int cycles = 0;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", pending);
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  // Write all six line registers
  task automatic set_line(coord_t ps [6]);
    logic [REG_IDX_W-1:0] regs [6];
    regs = '{REG_LINE_START_X, REG_LINE_START_Y, REG_LINE_START_Z,
             REG_LINE_END_X, REG_LINE_END_Y, REG_LINE_END_Z};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_wdata_i <= ps[i];
      line_cur[i] = ps[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Offer one segment; returns once it is taken, at times after a random gap with valid low
  task automatic send_segment(coord_t s0 [3], coord_t s1 [3]);
    bit rdy;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s1[2], s1[1], s1[0], s0[2], s0[1], s0[0]};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic coord_t along(int i, int frac);
    longint d;
    d = longint'(line_cur[i+3]) - longint'(line_cur[i]);
    return coord_t'(longint'(line_cur[i]) + ((d * frac) >>> 8));
  endfunction

  // Segment end as a point on the line, t = frac/256, with optional noise
  task automatic send_on_line(int f0, int f1, int noise);
    coord_t s0 [3], s1 [3];
    for (int i = 0; i < 3; i++) begin
      s0[i] = along(i, f0) + ((noise > 0) ? coord_t'($urandom_range(0, noise)) : 0);
      s1[i] = along(i, f1) + ((noise > 0) ? coord_t'($urandom_range(0, noise)) : 0);
    end
    send_segment(s0, s1);
  endtask

  task automatic random_segments(int n);
    coord_t s0 [3], s1 [3];
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        send_on_line($urandom_range(0, 1024) - 384, $urandom_range(0, 1024) - 384,
                     ($urandom_range(0, 1) == 1) ? (1 << $urandom_range(0, 20)) : 0);
      end else begin
        for (int i = 0; i < 3; i++) begin
          s0[i] = $urandom();
          s1[i] = $urandom();
        end
        send_segment(s0, s1);
      end
    end
  endtask

  // Directed cases: field extremes, ends on the line, disjoint, covering, reversed
  task automatic directed_segments();
    coord_t lo3 [3], hi3 [3], z3 [3];
    lo3 = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    hi3 = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    z3  = '{0, 0, 0};
    send_segment(lo3, hi3);
    send_segment(hi3, lo3);
    send_segment(lo3, lo3);
    send_segment(hi3, hi3);
    send_segment(z3, z3);
    send_on_line(0, 256, 0);      // exactly the line
    send_on_line(256, 0, 0);      // reversed
    send_on_line(0, 0, 0);        // zero length at the start
    send_on_line(0, 128, 0);      // starts at t = 0
    send_on_line(-256, -64, 0);   // wholly before the start
    send_on_line(320, 600, 0);    // wholly past the end
    send_on_line(-128, 512, 0);   // covers the line
    send_on_line(-128, 128, 4096);
    send_on_line(128, 512, 4096);
    send_on_line(64, 192, 1 << 20);
  endtask

  initial begin
    coord_t lines [6][6];
    lines[0] = '{0, 0, 0, 10 << 16, 0, 0};
    lines[1] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    lines[2] = '{32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000, 1, 32'sh7FFF_FFFF};
    lines[3] = '{5 << 16, -3 << 16, 7, 5 << 16, -3 << 16, 7};  // zero-length line
    lines[4] = '{1, 2, 3, 4, 6, 3};
    for (int i = 0; i < 6; i++) begin
      line_cur[i] = 0;
      lines[5][i] = $urandom() >>> $urandom_range(0, 12);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset line is zero length
    directed_segments();
    random_segments(20);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      set_line(lines[p]);
      if (p == 1) hold_req = 1'b1;
      directed_segments();
      if (p == 5) begin
        random_segments(ITEMS_PER_LINE - 150);
        calm = 1'b1;
        random_segments(150);
      end else begin
        random_segments(ITEMS_PER_LINE);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    $display("%0d segments sent, %0d results checked (%0d on a zero-length line)",
             sent, checked, degen_seen);
    $display("%0d line settings incl. reset, extremes and zero length; long output hold-off",
             settings);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- segment_to_line_metrics_core.f -----
rtl/stlm_pkg.sv
rtl/stlm_div.sv
rtl/stlm_geom.sv
rtl/stlm_energy.sv
rtl/segment_to_line_metrics_core.sv
verif/segment_to_line_metrics_checker.sv
verif/segment_to_line_metrics_core_tb.sv
